// ===== rtl/ipv4rt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4rt_pkg
// shared transaction types and status codes of the ipv4 range text parser
// ----------------------------------------------------------------------------
package ipv4rt_pkg;

  // one character of the range text
  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } char_item_t;

  // one parsed range
  typedef struct packed {
    logic [31:0] first_address;
    logic [31:0] last_address;
    logic [2:0]  status;
  } range_item_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_COMPONENT = 3'd1;
  localparam logic [2:0] ST_TOO_FEW   = 3'd2;
  localparam logic [2:0] ST_TOO_MANY  = 3'd3;
  localparam logic [2:0] ST_PREFIX    = 3'd4;
  localparam logic [2:0] ST_BAD_CHAR  = 3'd5;

  localparam logic [9:0] ACC_MAX      = 10'd1023;
  localparam logic [9:0] OCTET_MAX    = 10'd255;
  localparam logic [9:0] PREFIX_MAX   = 10'd32;
  localparam logic [2:0] QUAD_COUNT   = 3'd4;

  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_DASH      = 8'h2D;
  localparam logic [7:0] CH_SLASH     = 8'h2F;

endpackage

// ===== rtl/ipv4_range_text_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_range_text_parser
// parses one ipv4 range text, one ascii character per transaction
// ----------------------------------------------------------------------------
// usage
//   char channel: char_valid / char_stall / char_item carry one character per
//   transaction; end_of_text marks the last character of a text
//   res channel: res_valid / res_stall / res_item carry one range per text,
//   given for the transaction that had end_of_text set
//   accepted forms: a.b.c.d, a.b.c.d/p (p 0..32), a.b.c.d-x[.y[.z[.w]]]
//   on any error status is nonzero and both addresses are zero
// throughput and registers
//   one character per cycle while no final character waits behind a held
//   result; a character is held in the input register, and its result (if
//   any) is loaded from there into the result register, where the range
//   stays until it is taken
// stall behavior
//   the result register holds while res_stall is high; only a final
//   character waits in the input register behind a held result, all other
//   characters keep flowing
// reset
//   rst (synchronous) empties both registers and returns the parser to the
//   start of a text
// ----------------------------------------------------------------------------
module ipv4_range_text_parser (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      char_valid,
  output logic                      char_stall,
  input  ipv4rt_pkg::char_item_t    char_item,
  output logic                      res_valid,
  input  logic                      res_stall,
  output ipv4rt_pkg::range_item_t   res_item
);

  // parse phase codes
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_PREFIX = 2'd2;

  // result of closing one address component
  typedef struct packed {
    logic        done;
    logic [2:0]  cnt;
    logic [31:0] val;
    logic [2:0]  err;
  } close_t;

  function automatic close_t close_comp(input logic [2:0]  cnt,
                                        input logic [9:0]  acc,
                                        input logic        seen,
                                        input logic [31:0] val,
                                        input logic [2:0]  err);
    close_t r;
    r.done = 1'b0;
    r.cnt  = cnt;
    r.val  = val;
    r.err  = err;
    if (cnt < ipv4rt_pkg::QUAD_COUNT) begin
      if ((!seen || acc > ipv4rt_pkg::OCTET_MAX) && err == ipv4rt_pkg::ST_OK) begin
        r.err = ipv4rt_pkg::ST_COMPONENT;
      end
      r.val  = {val[23:0], acc[7:0]};
      r.cnt  = cnt + 3'd1;
      r.done = 1'b1;
    end
    return r;
  endfunction

  // input register
  logic                   s1_valid;
  ipv4rt_pkg::char_item_t s1_item;
  logic                   s1_go;

  // parser state
  logic [1:0]  phase;
  logic [2:0]  component_count;
  logic [9:0]  digit_accumulator;
  logic        digit_seen;
  logic [31:0] first_value;
  logic [31:0] second_value;
  logic [2:0]  error_code;

  logic [1:0]  phase_next;
  logic [2:0]  component_count_next;
  logic [9:0]  digit_accumulator_next;
  logic        digit_seen_next;
  logic [31:0] first_value_next;
  logic [31:0] second_value_next;
  logic [2:0]  error_code_next;
  ipv4rt_pkg::range_item_t res_item_next;

  // a final character waits only when the held result is not being taken
  assign s1_go      = s1_valid && !(s1_item.end_of_text && res_valid && res_stall);
  assign char_stall = s1_valid && !s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!char_stall) begin
      s1_valid <= char_valid;
    end
    if (char_valid && !char_stall) begin
      s1_item <= char_item;
    end
  end

  // character step plus end-of-text finish, in one pass
  always_comb begin
    close_t      cl;
    logic [13:0] sum;
    logic [31:0] keep;
    logic [31:0] mask;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [7:0]  c;

    phase_next             = phase;
    component_count_next   = component_count;
    digit_accumulator_next = digit_accumulator;
    digit_seen_next        = digit_seen;
    first_value_next       = first_value;
    second_value_next      = second_value;
    error_code_next        = error_code;
    cl                     = '0;
    lo                     = '0;
    hi                     = '0;
    keep                   = '1;
    mask                   = '0;
    sum                    = '0;
    c                      = s1_item.char_code;

    if (c inside {[ipv4rt_pkg::CH_ZERO:ipv4rt_pkg::CH_NINE]}) begin
      // acc * 10 + digit, saturating
      sum = ({4'd0, digit_accumulator} << 3) + ({4'd0, digit_accumulator} << 1)
          + {10'd0, c[3:0]};
      digit_accumulator_next = (sum > {4'd0, ipv4rt_pkg::ACC_MAX}) ?
                               ipv4rt_pkg::ACC_MAX : sum[9:0];
      digit_seen_next = 1'b1;
    end else if (c == ipv4rt_pkg::CH_DOT && phase != PH_PREFIX) begin
      cl = close_comp(component_count, digit_accumulator, digit_seen,
                      (phase == PH_FIRST) ? first_value : second_value, error_code);
      component_count_next = cl.cnt;
      error_code_next      = cl.err;
      if (phase == PH_FIRST) begin
        first_value_next = cl.val;
      end else begin
        second_value_next = cl.val;
      end
      if (cl.done) begin
        digit_accumulator_next = '0;
        digit_seen_next        = 1'b0;
      end
      if (cl.cnt >= ipv4rt_pkg::QUAD_COUNT && error_code_next == ipv4rt_pkg::ST_OK) begin
        error_code_next = ipv4rt_pkg::ST_TOO_MANY;
      end
    end else if ((c == ipv4rt_pkg::CH_DASH || c == ipv4rt_pkg::CH_SLASH) &&
                 phase == PH_FIRST) begin
      cl = close_comp(component_count, digit_accumulator, digit_seen,
                      first_value, error_code);
      first_value_next = cl.val;
      error_code_next  = cl.err;
      if (cl.cnt < ipv4rt_pkg::QUAD_COUNT && error_code_next == ipv4rt_pkg::ST_OK) begin
        error_code_next = ipv4rt_pkg::ST_TOO_FEW;
      end
      phase_next             = (c == ipv4rt_pkg::CH_DASH) ? PH_SECOND : PH_PREFIX;
      component_count_next   = '0;
      digit_accumulator_next = '0;
      digit_seen_next        = 1'b0;
    end else begin
      error_code_next = ipv4rt_pkg::ST_BAD_CHAR;
    end

    // finish the text
    case (phase_next)
      PH_FIRST: begin
        cl = close_comp(component_count_next, digit_accumulator_next, digit_seen_next,
                        first_value_next, error_code_next);
        if (cl.cnt < ipv4rt_pkg::QUAD_COUNT && cl.err == ipv4rt_pkg::ST_OK) begin
          cl.err = ipv4rt_pkg::ST_TOO_FEW;
        end
        lo = cl.val;
        hi = cl.val;
        res_item_next.status = cl.err;
      end
      PH_SECOND: begin
        cl = close_comp(component_count_next, digit_accumulator_next, digit_seen_next,
                        second_value_next, error_code_next);
        // missing high octets come from the first address
        case (cl.cnt)
          3'd1:    keep = 32'hFFFF_FF00;
          3'd2:    keep = 32'hFFFF_0000;
          3'd3:    keep = 32'hFF00_0000;
          default: keep = 32'h0000_0000;
        endcase
        hi = (first_value_next & keep) | cl.val;
        lo = first_value_next;
        if (lo > hi) begin
          lo = hi;
          hi = first_value_next;
        end
        res_item_next.status = cl.err;
      end
      default: begin
        res_item_next.status = error_code_next;
        if (error_code_next != ipv4rt_pkg::ST_BAD_CHAR &&
            (!digit_seen_next || digit_accumulator_next > ipv4rt_pkg::PREFIX_MAX)) begin
          res_item_next.status = ipv4rt_pkg::ST_PREFIX;
        end
        if (digit_accumulator_next != 10'd0 &&
            digit_accumulator_next <= ipv4rt_pkg::PREFIX_MAX) begin
          mask = ~(32'hFFFF_FFFF >> digit_accumulator_next[5:0]);
        end
        lo = first_value_next & mask;
        hi = first_value_next | ~mask;
      end
    endcase

    if (res_item_next.status != ipv4rt_pkg::ST_OK) begin
      lo = '0;
      hi = '0;
    end
    res_item_next.first_address = lo;
    res_item_next.last_address  = hi;

    // a finished text leaves the parser at the start
    if (s1_item.end_of_text) begin
      phase_next             = PH_FIRST;
      component_count_next   = '0;
      digit_accumulator_next = '0;
      digit_seen_next        = 1'b0;
      first_value_next       = '0;
      second_value_next      = '0;
      error_code_next        = ipv4rt_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_FIRST;
      component_count   <= '0;
      digit_accumulator <= '0;
      digit_seen        <= 1'b0;
      first_value       <= '0;
      second_value      <= '0;
      error_code        <= ipv4rt_pkg::ST_OK;
    end else if (s1_go) begin
      phase             <= phase_next;
      component_count   <= component_count_next;
      digit_accumulator <= digit_accumulator_next;
      digit_seen        <= digit_seen_next;
      first_value       <= first_value_next;
      second_value      <= second_value_next;
      error_code        <= error_code_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_go && s1_item.end_of_text) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
    if (s1_go && s1_item.end_of_text) begin
      res_item <= res_item_next;
    end
  end

  // checks
  a_ok_ordered: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.status == ipv4rt_pkg::ST_OK |->
      res_item.first_address <= res_item.last_address)
    else $error("ok range out of order");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.status != ipv4rt_pkg::ST_OK |->
      res_item.first_address == 32'd0 && res_item.last_address == 32'd0)
    else $error("error result with nonzero address");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_item.status <= ipv4rt_pkg::ST_BAD_CHAR)
    else $error("status code out of range");

  a_phase_legal: assert property (@(posedge clk) disable iff (rst)
    phase != 2'd3 && component_count <= ipv4rt_pkg::QUAD_COUNT)
    else $error("parser state out of range");

  a_clear_after_text: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_item.end_of_text |=>
      phase == PH_FIRST && component_count == 3'd0 &&
      error_code == ipv4rt_pkg::ST_OK && !digit_seen)
    else $error("parser not cleared after end of text");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_item.end_of_text |=> res_valid)
    else $error("final character produced no result");

endmodule
